@@ hdl/fcr_pkg.sv @@
package fcr_pkg;

  localparam int COS_W      = 16;
  localparam int IDX_W      = 16;
  localparam int REG_W      = 48;
  localparam int REFL_W     = 16;
  localparam int ERR_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_LANES  = 3;
  localparam int CHANNELS_DEF = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_INCIDENT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONDUCTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABSORPTION = 2'd2;

  localparam logic [REG_W-1:0] INCIDENT_RST   = 48'h1000_1000_1000;
  localparam logic [REG_W-1:0] CONDUCTOR_RST  = 48'h1000_1000_1000;
  localparam logic [REG_W-1:0] ABSORPTION_RST = 48'h0;

  localparam int CMAG_W = 15;
  localparam int C2_W   = 29;
  localparam logic signed [COS_W:0] ONE_Q14 = 17'sd16384;
  localparam logic [C2_W-1:0] ONE_Q28 = 29'h1000_0000;

  localparam int FRAC_SH = 16;
  localparam int A_RAD_W = 60;
  localparam int A_W     = A_RAD_W / 2;
  localparam int S_ARG_W = 50;
  localparam int S_W     = S_ARG_W / 2;
  localparam int DIV_Q   = 34;
  localparam int DIV_DW  = 33;
  localparam int RS_W    = 18;
  localparam int PP_W    = DIV_Q + 1;

  localparam logic [RS_W-1:0] RS_CAP  = 18'h2_0000;
  localparam logic [PP_W-1:0] Q_SAT   = 35'h4_0000_0000;
  localparam logic [PP_W-1:0] ONE_Q16 = 35'h1_0000;
  localparam logic [REFL_W-1:0] FULL_SCALE = 16'hFFFF;

  localparam int LANE_LAT  = 4 + A_W + 1 + S_W + 4 + DIV_Q + 2;
  localparam int TOTAL_LAT = LANE_LAT + 2;

  typedef struct packed {
    logic [C2_W-1:0]   c2;
    logic [C2_W-1:0]   s2;
    logic [CMAG_W-1:0] cmag;
    logic              cneg;
  } item_t;

  typedef struct packed {
    logic [REFL_W-1:0] refl;
    logic              err;
  } lane_out_t;

endpackage

@@ hdl/fcr_delay.sv @@
module fcr_delay import fcr_pkg::*; #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    tap_r[0] <= din;
  end

  for (genvar k = 1; k < N; k++) begin : g_tap
    always_ff @(posedge clk) begin
      tap_r[k] <= tap_r[k-1];
    end
  end

  assign dout = tap_r[N-1];

endmodule

@@ hdl/fcr_sqrt_pipe.sv @@
module fcr_sqrt_pipe import fcr_pkg::*; #(
  parameter int IW = A_RAD_W
) (
  input  logic            clk,
  input  logic [IW-1:0]   radicand,
  output logic [IW/2-1:0] root
);

  localparam int RW = IW / 2;

  logic [RW:0]   rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [IW-1:0] rest_r [RW];

  // One root bit per stage, restoring digit-by-digit method.
  for (genvar j = 0; j < RW; j++) begin : g_st
    logic [RW:0]   rem_in;
    logic [RW-1:0] root_in;
    logic [IW-1:0] rest_in;
    logic [RW+2:0] sh;
    logic [RW+2:0] trial;
    logic          ge;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = radicand;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rest_in = rest_r[j-1];
    end
    assign sh    = {rem_in, rest_in[IW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = sh >= trial;
    always_ff @(posedge clk) begin
      rem_r[j]  <= ge ? (RW+1)'(sh - trial) : sh[RW:0];
      root_r[j] <= {root_in[RW-2:0], ge};
      rest_r[j] <= rest_in << 2;
    end
  end

  assign root = root_r[RW-1];

endmodule

@@ hdl/fcr_div_pipe.sv @@
module fcr_div_pipe import fcr_pkg::*; #(
  parameter int QW = DIV_Q,
  parameter int DW = DIV_DW
) (
  input  logic          clk,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot
);

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] bits_r [QW];
  logic [QW-1:0] quo_r [QW];

  // Divides num << FRAC_SH by den, one quotient bit per stage. The caller
  // guarantees that the quotient fits in QW bits.
  for (genvar j = 0; j < QW; j++) begin : g_st
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] bits_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   sh;
    logic          ge;
    if (j == 0) begin : g_first
      assign rem_in  = DW'(num >> (QW - FRAC_SH));
      assign den_in  = den;
      assign bits_in = {num[QW-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign bits_in = bits_r[j-1];
      assign quo_in  = quo_r[j-1];
    end
    assign sh = {rem_in, bits_in[QW-1]};
    assign ge = sh >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      rem_r[j]  <= ge ? DW'(sh - {1'b0, den_in}) : sh[DW-1:0];
      den_r[j]  <= den_in;
      bits_r[j] <= bits_in << 1;
      quo_r[j]  <= {quo_in[QW-2:0], ge};
    end
  end

  assign quot = quo_r[QW-1];

endmodule

@@ hdl/fcr_lane.sv @@
module fcr_lane import fcr_pkg::*; (
  input  logic             clk,
  input  item_t            item,
  input  logic [IDX_W-1:0] ii,
  input  logic [IDX_W-1:0] tt,
  input  logic [IDX_W-1:0] kk,
  output lane_out_t        res
);

  localparam int TA = 4 + A_W;
  localparam int TS = TA + 1 + S_W;

  // Squares of the indices; the user must keep configuration quiet while items are in flight (unchecked).
  logic [31:0] sq_i, sq_t, sq_k;
  logic [27:0] i2_r, t2_r, k2_r;
  logic [57:0] tk4_r;

  assign sq_i = {16'b0, ii} * {16'b0, ii};
  assign sq_t = {16'b0, tt} * {16'b0, tt};
  assign sq_k = {16'b0, kk} * {16'b0, kk};

  always_ff @(posedge clk) begin
    i2_r  <= sq_i[31:4];
    t2_r  <= sq_t[31:4];
    k2_r  <= sq_k[31:4];
    tk4_r <= {56'(56'(t2_r) * 56'(k2_r)), 2'b00};
  end

  // Front terms.
  logic [56:0] si2_p, ci2_p;
  logic [57:0] s4_p;
  logic [27:0] si2_r, ci2_r;
  logic [28:0] s4_r;
  logic [30:0] m1_r;
  logic signed [29:0] n0_r;
  logic [56:0] s4i2_p;
  logic [27:0] s4i2_r;
  logic [29:0] u;
  logic [59:0] uu_p;
  logic [58:0] uu_r;
  logic [A_RAD_W-1:0] rad_r;

  assign si2_p  = 57'(item.s2) * 57'(i2_r);
  assign ci2_p  = 57'(item.c2) * 57'(i2_r);
  assign s4_p   = 58'(item.s2) * 58'(item.s2);
  assign s4i2_p = 57'(s4_r) * 57'(i2_r);
  assign u      = n0_r[29] ? 30'(-n0_r) : 30'(n0_r);
  assign uu_p   = 60'(u) * 60'(u);

  always_ff @(posedge clk) begin
    si2_r  <= si2_p[55:28];
    ci2_r  <= ci2_p[55:28];
    s4_r   <= s4_p[56:28];
    m1_r   <= 31'(31'(item.cmag) * 31'(ii));
    n0_r   <= $signed(30'(t2_r) - 30'(k2_r) - 30'(si2_r));
    s4i2_r <= s4i2_p[55:28];
    uu_r   <= uu_p[58:0];
    rad_r  <= 60'(uu_r) + 60'(tk4_r);
  end

  logic [A_W-1:0] a_root;

  fcr_sqrt_pipe #(.IW(A_RAD_W)) u_sqrt_a (
    .clk(clk), .radicand(rad_r), .root(a_root)
  );

  logic [29:0]   n0_d;
  logic [27:0]   ci2_d, s4i2_d;
  logic [C2_W-1:0] c2_d, s2_d;
  logic [30:0]   m1_d;
  logic          cneg_d;

  fcr_delay #(.W(30), .N(TA-2)) u_d_n0 (.clk(clk), .din(n0_r), .dout(n0_d));
  fcr_delay #(.W(28), .N(TA-1)) u_d_ci2 (.clk(clk), .din(ci2_r), .dout(ci2_d));
  fcr_delay #(.W(28), .N(TA-1)) u_d_s4i2 (.clk(clk), .din(s4i2_r), .dout(s4i2_d));
  fcr_delay #(.W(C2_W), .N(TA)) u_d_c2 (.clk(clk), .din(item.c2), .dout(c2_d));
  fcr_delay #(.W(C2_W), .N(TS+1)) u_d_s2 (.clk(clk), .din(item.s2), .dout(s2_d));
  fcr_delay #(.W(31), .N(TS-1)) u_d_m1 (.clk(clk), .din(m1_r), .dout(m1_d));
  fcr_delay #(.W(1), .N(TS+2)) u_d_cneg (.clk(clk), .din(item.cneg), .dout(cneg_d));

  // Terms after the first root.
  logic [31:0] an0;
  logic [58:0] ca_p;
  logic [S_ARG_W-1:0] sarg_r;
  logic [30:0] t1_r, t3_r;
  logic [29:0] ca_r;

  assign an0  = 32'(a_root) + {{2{n0_d[29]}}, n0_d};
  assign ca_p = 59'(c2_d) * 59'(a_root);

  always_ff @(posedge clk) begin
    sarg_r <= {an0[30:0], 19'b0};
    t1_r   <= 31'(a_root) + 31'(ci2_d);
    ca_r   <= ca_p[57:28];
    t3_r   <= 31'(ca_r) + 31'(s4i2_d);
  end

  logic [S_W-1:0] s_root;

  fcr_sqrt_pipe #(.IW(S_ARG_W)) u_sqrt_s (
    .clk(clk), .radicand(sarg_r), .root(s_root)
  );

  logic [30:0] t1_d, t3_d;

  fcr_delay #(.W(31), .N(S_W)) u_d_t1 (.clk(clk), .din(t1_r), .dout(t1_d));
  fcr_delay #(.W(31), .N(S_W-1)) u_d_t3 (.clk(clk), .din(t3_r), .dout(t3_d));

  // Cross terms and the two quotient operands.
  logic [55:0] m_r;
  logic [30:0] t1_p1_r, t3_p1_r, t1_p2_r, t3_p2_r, t2mag_r;
  logic [59:0] t4mul_r;
  logic signed [33:0] t2s, t4s;
  logic signed [33:0] den1_r, num1_r, den2_r, num2_r;

  assign t2s = cneg_d ? -$signed(34'(t2mag_r)) : $signed(34'(t2mag_r));
  assign t4s = cneg_d ? -$signed(34'(t4mul_r[58:28])) : $signed(34'(t4mul_r[58:28]));

  always_ff @(posedge clk) begin
    m_r     <= 56'(m1_d) * 56'(s_root);
    t1_p1_r <= t1_d;
    t3_p1_r <= t3_d;
    t2mag_r <= m_r[55:25];
    t4mul_r <= 60'(m_r[55:25]) * 60'(s2_d);
    t1_p2_r <= t1_p1_r;
    t3_p2_r <= t3_p1_r;
    den1_r  <= $signed(34'(t1_p2_r)) + t2s;
    num1_r  <= $signed(34'(t1_p2_r)) - t2s;
    den2_r  <= $signed(34'(t3_p2_r)) + t4s;
    num2_r  <= $signed(34'(t3_p2_r)) - t4s;
  end

  // A divisor that is not positive flags the lane; a quotient too large for
  // the divider is flagged as saturated and the divider gets a zero dividend.
  logic e1, e2, sat1, sat2;
  logic [DIV_DW-1:0] n1, n2, d1, d2;
  logic [DIV_DW-1:0] dn1_r, dn2_r, dd1_r, dd2_r;
  logic [2:0] flag_r, flag_d;

  assign e1 = den1_r[33] || (den1_r == '0);
  assign e2 = den2_r[33] || (den2_r == '0);
  assign n1 = num1_r[33] ? '0 : num1_r[32:0];
  assign n2 = num2_r[33] ? '0 : num2_r[32:0];
  assign d1 = e1 ? DIV_DW'(1) : den1_r[32:0];
  assign d2 = e2 ? DIV_DW'(1) : den2_r[32:0];
  assign sat1 = {18'b0, n1} >= {d1, 18'b0};
  assign sat2 = {18'b0, n2} >= {d2, 18'b0};

  always_ff @(posedge clk) begin
    dn1_r  <= sat1 ? '0 : n1;
    dn2_r  <= sat2 ? '0 : n2;
    dd1_r  <= d1;
    dd2_r  <= d2;
    flag_r <= {e1 || e2, sat2, sat1};
  end

  logic [DIV_Q-1:0] quo1, quo2;

  fcr_div_pipe #(.QW(DIV_Q), .DW(DIV_DW)) u_div_rs (
    .clk(clk), .num(dn1_r), .den(dd1_r), .quot(quo1)
  );
  fcr_div_pipe #(.QW(DIV_Q), .DW(DIV_DW)) u_div_q (
    .clk(clk), .num(dn2_r), .den(dd2_r), .quot(quo2)
  );
  fcr_delay #(.W(3), .N(DIV_Q)) u_d_flag (.clk(clk), .din(flag_r), .dout(flag_d));

  // Final product, split in two partial products.
  logic [RS_W-1:0] rs;
  logic [PP_W-1:0] pp;
  logic [34:0] ph_r;
  logic [35:0] pl_r;
  logic        err_r;
  logic [53:0] prod;
  logic [36:0] rq;
  logic        err_fin;

  assign rs = flag_d[0] ? RS_CAP :
              ((quo1 > DIV_Q'(RS_CAP)) ? RS_CAP : quo1[RS_W-1:0]);
  assign pp = ONE_Q16 + (flag_d[1] ? Q_SAT : PP_W'(quo2));

  always_ff @(posedge clk) begin
    ph_r  <= 35'(rs) * 35'(pp[PP_W-1:18]);
    pl_r  <= 36'(rs) * 36'(pp[17:0]);
    err_r <= flag_d[2];
  end

  assign prod    = {1'b0, ph_r, 18'b0} + 54'(pl_r);
  assign rq      = prod[53:17];
  assign err_fin = err_r || (ii == '0);

  always_ff @(posedge clk) begin
    res.err  <= err_fin;
    if (err_fin || (rq > 37'(FULL_SCALE))) begin
      res.refl <= FULL_SCALE;
    end else begin
      res.refl <= rq[REFL_W-1:0];
    end
  end

endmodule

@@ hdl/conductor_fresnel_reflectance_core.sv @@
// Conductor Fresnel reflectance, one item per clock cycle, fully pipelined.
// The delay from the accepting edge to out_valid is set by the two bit-per-stage
// square roots and the bit-per-stage divider.
// busy stays low: an item may be started in every cycle, results are never held.
// Synchronous reset restores the configuration registers and drops every
// item in flight.
module conductor_fresnel_reflectance_core import fcr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [COS_W-1:0]     in_cos_incident,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output logic                 out_valid,
  output logic [REFL_W-1:0]    out_refl_red,
  output logic [REFL_W-1:0]    out_refl_green,
  output logic [REFL_W-1:0]    out_refl_blue,
  output logic [ERR_W-1:0]     out_divide_error_lanes
);

  logic [REG_W-1:0] incident_r, conductor_r, absorption_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incident_r   <= INCIDENT_RST;
      conductor_r  <= CONDUCTOR_RST;
      absorption_r <= ABSORPTION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INCIDENT:   incident_r   <= cfg_data;
        CFG_CONDUCTOR:  conductor_r  <= cfg_data;
        CFG_ABSORPTION: absorption_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  logic [TOTAL_LAT-1:0] valid_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[TOTAL_LAT-2:0], accept};
    end
  end

  // Clamp the cosine to plus or minus one and split off its sign.
  logic signed [COS_W:0] c;
  logic [CMAG_W-1:0] cmag_nxt, cmag_r;
  logic              cneg_nxt, cneg_r;
  logic [29:0]       c2_full;
  item_t             item_r;

  assign c = $signed({in_cos_incident[COS_W-1], in_cos_incident});

  always_comb begin
    if (c > ONE_Q14) begin
      cmag_nxt = CMAG_W'(ONE_Q14);
      cneg_nxt = 1'b0;
    end else if (c < -ONE_Q14) begin
      cmag_nxt = CMAG_W'(ONE_Q14);
      cneg_nxt = 1'b1;
    end else begin
      cneg_nxt = c[COS_W];
      cmag_nxt = cneg_nxt ? CMAG_W'(-c) : CMAG_W'(c);
    end
  end

  assign c2_full = 30'(cmag_r) * 30'(cmag_r);

  always_ff @(posedge clk) begin
    cmag_r      <= cmag_nxt;
    cneg_r      <= cneg_nxt;
    item_r.c2   <= c2_full[C2_W-1:0];
    item_r.s2   <= ONE_Q28 - c2_full[C2_W-1:0];
    item_r.cmag <= cmag_r;
    item_r.cneg <= cneg_r;
  end

  lane_out_t lane_res [MAX_LANES];

  for (genvar l = 0; l < MAX_LANES; l++) begin : g_lane
    if (l < CHANNELS) begin : g_on
      fcr_lane u_lane (
        .clk (clk),
        .item(item_r),
        .ii  (incident_r[IDX_W*l +: IDX_W]),
        .tt  (conductor_r[IDX_W*l +: IDX_W]),
        .kk  (absorption_r[IDX_W*l +: IDX_W]),
        .res (lane_res[l])
      );
    end else begin : g_off
      assign lane_res[l] = '0;
    end
  end

  assign out_valid              = valid_r[TOTAL_LAT-1];
  assign out_refl_red           = lane_res[0].refl;
  assign out_refl_green         = lane_res[1].refl;
  assign out_refl_blue          = lane_res[2].refl;
  assign out_divide_error_lanes = {lane_res[2].err, lane_res[1].err, lane_res[0].err};

endmodule

@@ dv/conductor_fresnel_reflectance_core_tb.sv @@
`timescale 1ns / 100ps

module conductor_fresnel_reflectance_core_tb import fcr_pkg::*;;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 60000;
  localparam int PHASE_COUNT = 7;
  localparam int RAND_ITEMS  = 91;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [REFL_W-1:0] red;
    logic [REFL_W-1:0] green;
    logic [REFL_W-1:0] blue;
    logic [ERR_W-1:0]  err;
  } refl_item_t;

  class refl_scoreboard;
    logic [REG_W-1:0] incident_idx;
    logic [REG_W-1:0] conductor_idx;
    logic [REG_W-1:0] absorb_k;
    refl_item_t       expected_q[$];
    int               mismatches;
    int               checked;
    int               err_items;

    function new();
      incident_idx  = INCIDENT_RST;
      conductor_idx = CONDUCTOR_RST;
      absorb_k      = ABSORPTION_RST;
      mismatches    = 0;
      checked       = 0;
      err_items     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        CFG_INCIDENT:   incident_idx = val;
        CFG_CONDUCTOR:  conductor_idx = val;
        CFG_ABSORPTION: absorb_k = val;
        default: ;
      endcase
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, b;
      root = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    // Conductor Fresnel terms for one lane, all scaled by the incident index squared.
    function automatic logic [REFL_W-1:0] lane_reflect(longint unsigned cmag, bit neg,
        longint unsigned c2, longint unsigned s2, longint unsigned ii,
        longint unsigned tt, longint unsigned kk, output bit err);
      longint unsigned i2, t2, k2, si2, mag, a, s, t2mag, t4mag, rs, q, r;
      longint n0, t1, t2s, t3, t4, num, den;
      err = 0;
      if (ii == 0) begin
        err = 1;
        return FULL_SCALE;
      end
      i2  = (ii * ii) >> 4;
      t2  = (tt * tt) >> 4;
      k2  = (kk * kk) >> 4;
      si2 = (s2 * i2) >> 28;
      n0  = longint'(t2) - longint'(k2) - longint'(si2);
      mag = (n0 < 0) ? u64_t'(-n0) : u64_t'(n0);
      a   = int_sqrt(mag * mag + 4 * t2 * k2);
      s   = int_sqrt(u64_t'(longint'(a) + n0) << 19);
      t1    = longint'(a + ((c2 * i2) >> 28));
      t2mag = (2 * cmag * ii * s) >> 26;
      t2s   = neg ? -longint'(t2mag) : longint'(t2mag);
      t3    = longint'(((c2 * a) >> 28) + ((((s2 * s2) >> 28) * i2) >> 28));
      t4mag = (t2mag * s2) >> 28;
      t4    = neg ? -longint'(t4mag) : longint'(t4mag);
      den = t1 + t2s;
      if (den <= 0) begin
        err = 1;
        return FULL_SCALE;
      end
      num = t1 - t2s;
      if (num < 0) num = 0;
      rs = (u64_t'(num) << 16) / u64_t'(den);
      if (rs > 64'd131072) rs = 64'd131072;
      den = t3 + t4;
      if (den <= 0) begin
        err = 1;
        return FULL_SCALE;
      end
      num = t3 - t4;
      if (num < 0) num = 0;
      q = (u64_t'(num) << 16) / u64_t'(den);
      if (q > 64'd1099511627776) q = 64'd1099511627776;
      r = (rs * (64'd65536 + q)) >> 17;
      return (r > 64'd65535) ? FULL_SCALE : r[REFL_W-1:0];
    endfunction

    function void note_cosine(logic [COS_W-1:0] raw);
      refl_item_t      exp_item;
      longint          c;
      longint unsigned cmag, c2, s2;
      logic [REFL_W-1:0] lanes [MAX_LANES];
      bit              err;
      c = longint'($signed(raw));
      if (c > 16384) c = 16384;
      if (c < -16384) c = -16384;
      cmag = (c < 0) ? u64_t'(-c) : u64_t'(c);
      c2 = cmag * cmag;
      s2 = 64'd268435456 - c2;
      exp_item.err = '0;
      for (int ln = 0; ln < MAX_LANES; ln++) begin
        lanes[ln] = '0;
        if (ln < CHANNELS_DEF) begin
          lanes[ln] = lane_reflect(cmag, c < 0, c2, s2, incident_idx[16*ln +: 16],
                                   conductor_idx[16*ln +: 16], absorb_k[16*ln +: 16], err);
          exp_item.err[ln] = err;
        end
      end
      exp_item.red   = lanes[0];
      exp_item.green = lanes[1];
      exp_item.blue  = lanes[2];
      expected_q.push_back(exp_item);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatches++;
    endtask

    task check_result(refl_item_t got);
      refl_item_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.err != 0) err_items++;
      if (got.red !== want.red) report("refl_red", got.red, want.red);
      if (got.green !== want.green) report("refl_green", got.green, want.green);
      if (got.blue !== want.blue) report("refl_blue", got.blue, want.blue);
      if (got.err !== want.err) report("divide_error_lanes", got.err, want.err);
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [COS_W-1:0]     in_cos_incident;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 out_valid;
  logic [REFL_W-1:0]    out_refl_red;
  logic [REFL_W-1:0]    out_refl_green;
  logic [REFL_W-1:0]    out_refl_blue;
  logic [ERR_W-1:0]     out_divide_error_lanes;

  refl_scoreboard refl_sb;
  int             cycle_count;
  int             items_sent;

  conductor_fresnel_reflectance_core u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_cos_incident        (in_cos_incident),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .out_valid              (out_valid),
    .out_refl_red           (out_refl_red),
    .out_refl_green         (out_refl_green),
    .out_refl_blue          (out_refl_blue),
    .out_divide_error_lanes (out_divide_error_lanes)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("conductor_fresnel_reflectance_core_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    refl_item_t got;
    if (rst_n && out_valid) begin
      got.red   = out_refl_red;
      got.green = out_refl_green;
      got.blue  = out_refl_blue;
      got.err   = out_divide_error_lanes;
      refl_sb.check_result(got);
    end
  end

  task send_cosine(logic [COS_W-1:0] raw, bit may_idle);
    if (may_idle) begin
      while ($urandom_range(0, 99) < 28) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_cos_incident <= raw;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    refl_sb.note_cosine(raw);
    items_sent++;
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    refl_sb.set_reg(idx, val);
  endtask

  task drain_pipeline();
    start <= 1'b0;
    while (refl_sb.expected_q.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] rand_reg();
    return REG_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [COS_W-1:0] rand_cosine();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return COS_W'($signed($urandom_range(0, 32768)) - 16384);
    if (sel < 75) return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
    return COS_W'($urandom());
  endfunction

  logic [COS_W-1:0] directed_cos [] = '{16'h8000, 16'h7FFF, 16'h4000, 16'hC000,
      16'h4001, 16'hBFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h2000, 16'hE000,
      16'h3FFF, 16'hC001, 16'h5555, 16'hAAAA, 16'h2D41};

  initial begin
    logic [REG_W-1:0] inc_v, con_v, abs_v;
    refl_sb = new();
    cycle_count = 0;
    items_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cos_incident = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_INCIDENT;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      // Phase 0 runs on the reset values; the rest cover extremes, random values and metals.
      if (ph > 0) begin
        case (ph)
          1: begin inc_v = 48'h1000_1000_1000; con_v = 48'h0300_0200_0280;
                   abs_v = 48'h3000_2800_2400; end
          2: begin inc_v = '0; con_v = '0; abs_v = '0; end
          3: begin inc_v = '1; con_v = '1; abs_v = '1; end
          4: begin inc_v = {rand_reg()} & 48'hFFFF_0000_FFFF; con_v = rand_reg();
                   abs_v = rand_reg(); end
          5: begin inc_v = rand_reg(); con_v = rand_reg(); abs_v = rand_reg(); end
          default: begin inc_v = 48'h1800_1555_1000; con_v = 48'h0400_0C00_0F00;
                         abs_v = 48'h0000_FFFF_0010; end
        endcase
        write_reg(CFG_INCIDENT, inc_v);
        write_reg(CFG_CONDUCTOR, con_v);
        write_reg(CFG_ABSORPTION, abs_v);
        cfg_we <= 1'b0;
      end
      foreach (directed_cos[i]) send_cosine(directed_cos[i], 1'b1);
      for (int n = 0; n < RAND_ITEMS; n++) begin
        // A run of back-to-back items in every phase.
        send_cosine(rand_cosine(), !(n >= 30 && n < 70));
      end
      drain_pipeline();
    end

    $display("checked %0d items over %0d register settings, %0d with a divide error",
             refl_sb.checked, PHASE_COUNT, refl_sb.err_items);
    if (refl_sb.mismatches == 0 && refl_sb.expected_q.size() == 0) begin
      $display("conductor_fresnel_reflectance_core_tb: PASS");
    end else begin
      $display("conductor_fresnel_reflectance_core_tb: FAIL");
    end
    $finish;
  end

endmodule
